// ===== rtl/core/rcpt_pkg.sv =====
package rcpt_pkg;

   // fixed field widths
   localparam int MODE_W   = 3;
   localparam int REASON_W = 3;
   localparam int REFS_W   = 32;
   localparam int SIZE_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 6;

   // operation codes
   typedef enum logic [MODE_W-1:0] {
      MODE_PIN   = 3'd0,
      MODE_UNPIN = 3'd1,
      MODE_QUERY = 3'd2,
      MODE_RANGE = 3'd3,
      MODE_CLEAR = 3'd4
   } mode_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   // sequencer states
   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_SCAN,
      S_CLEAR,
      S_ACT
   } state_type;

   // what the scan found over the whole table
   typedef struct packed {
      logic found;
      logic free_found;
      logic range_hit;
   } scan_flags_type;

endpackage

// ===== rtl/core/refcounted_pin_table_unit.sv =====
// flow: pin, unpin, query and range query scan every slot, then give their result
//   in the act state once the result register is free; clear first sweeps all slots
//   empty, unknown modes go straight to act; one transaction at a time, each scan
//   reading the slots one by one through the single read port of the table memory
// reset: synchronous; afterwards a clearing pass writes all CAPACITY slots empty,
//   one per cycle, before req_ready rises
module refcounted_pin_table_unit import rcpt_pkg::*; #(
   parameter int CAPACITY  = 32,
   parameter int ADDR_BITS = 48
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [MODE_W-1:0]    req_mode,
   input  logic [ADDR_BITS-1:0] req_obj_addr,
   input  logic [REASON_W-1:0]  req_pin_reason,
   input  logic [SIZE_W-1:0]    req_range_size,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [STATUS_W-1:0]  rsp_status,
   output logic                 rsp_hit,
   output logic [COUNT_W-1:0]   rsp_entry_count
);

   localparam int IDX_W   = $clog2(CAPACITY);
   localparam int LIVE_RW = $clog2(CAPACITY + 1);
   localparam int LIVE_W  = (LIVE_RW > COUNT_W) ? LIVE_RW : COUNT_W;
   localparam int ENT_W   = 1 + REASON_W + REFS_W + ADDR_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W:0]   END_CNT  = (IDX_W + 1)'(CAPACITY);

   state_type state_ff, state_in;
   logic [IDX_W:0]       cnt_ff, cnt_in;
   logic [MODE_W-1:0]    mode_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [REASON_W-1:0]  reason_ff;
   logic [SIZE_W-1:0]    size_ff;
   logic [LIVE_W-1:0]    live_ff, live_in;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_tag_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_hit_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   logic                 accept;
   logic                 rsp_free;
   logic                 rsp_load;
   status_type           status_res;
   logic                 hit_res;
   logic                 scan_start;

   logic                 rd_en;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_idx;
   logic                 wr_valid;
   logic [REASON_W-1:0]  wr_reason;
   logic [REFS_W-1:0]    wr_refs;
   logic [ENT_W-1:0]     wr_data;
   logic [ENT_W-1:0]     rd_data;

   logic                 ent_valid;
   logic [REASON_W-1:0]  ent_reason;
   logic [REFS_W-1:0]    ent_refs;
   logic [ADDR_BITS-1:0] ent_addr;

   scan_flags_type       flags;
   logic [IDX_W-1:0]     match_idx;
   logic [REASON_W-1:0]  match_reason;
   logic [REFS_W-1:0]    match_refs;
   logic [IDX_W-1:0]     free_idx;
   logic [REFS_W-1:0]    refs_dec;

   assign accept   = req_valid && req_ready;
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign refs_dec = match_refs - REFS_W'(1);

   // slot memory: {valid, reason, refs, addr}
   assign wr_data = {wr_valid, wr_reason, wr_refs, addr_ff};

   rcpt_ram #(
      .WIDTH (ENT_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_idx),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   assign ent_addr   = rd_data[ADDR_BITS-1:0];
   assign ent_refs   = rd_data[ADDR_BITS +: REFS_W];
   assign ent_reason = rd_data[ADDR_BITS+REFS_W +: REASON_W];
   assign ent_valid  = rd_data[ENT_W-1];

   rcpt_scan #(
      .CAPACITY  (CAPACITY),
      .ADDR_BITS (ADDR_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .start        (scan_start),
      .ent_vld      (rd_vld_ff),
      .ent_idx      (rd_tag_ff),
      .ent_valid    (ent_valid),
      .ent_addr     (ent_addr),
      .ent_reason   (ent_reason),
      .ent_refs     (ent_refs),
      .key_addr     (addr_ff),
      .key_size     (size_ff),
      .flags        (flags),
      .match_idx    (match_idx),
      .match_reason (match_reason),
      .match_refs   (match_refs),
      .free_idx     (free_idx)
   );

   // state register and control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         cnt_ff    <= '0;
         live_ff   <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         live_ff   <= live_in;
         rd_vld_ff <= rd_en;
      end
   end

   // read tag follows the registered read data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_tag_ff <= cnt_ff[IDX_W-1:0];
      end
   end

   // request capture
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff   <= req_mode;
         addr_ff   <= req_obj_addr;
         reason_ff <= req_pin_reason;
         size_ff   <= req_range_size;
      end
   end

   // next state, memory access and update of the table
   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      live_in    = live_ff;
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      wr_en      = 1'b0;
      wr_idx     = cnt_ff[IDX_W-1:0];
      wr_valid   = 1'b0;
      wr_reason  = reason_ff;
      wr_refs    = '0;
      scan_start = 1'b0;
      rsp_load   = 1'b0;
      status_res = ST_OK;
      hit_res    = 1'b0;
      unique case (state_ff)
         S_INIT, S_CLEAR: begin
            // sweep every slot to empty
            wr_en  = 1'b1;
            cnt_in = cnt_ff + (IDX_W + 1)'(1);
            if (cnt_ff[IDX_W-1:0] == LAST_IDX) begin
               cnt_in   = '0;
               state_in = (state_ff == S_INIT) ? S_IDLE : S_ACT;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cnt_in     = '0;
               scan_start = 1'b1;
               unique case (req_mode) inside
                  MODE_CLEAR: state_in = S_CLEAR;
                  MODE_PIN, MODE_UNPIN, MODE_QUERY, MODE_RANGE: state_in = S_SCAN;
                  default: state_in = S_ACT;
               endcase
            end
         end
         S_SCAN: begin
            // one slot read per cycle, compared in the next cycle
            if (cnt_ff != END_CNT) begin
               rd_en  = 1'b1;
               cnt_in = cnt_ff + (IDX_W + 1)'(1);
            end
            if (rd_vld_ff && (rd_tag_ff == LAST_IDX)) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
               cnt_in   = '0;
               unique case (mode_ff)
                  MODE_PIN: begin
                     if (flags.found) begin
                        wr_en     = 1'b1;
                        wr_idx    = match_idx;
                        wr_valid  = 1'b1;
                        wr_reason = match_reason;
                        wr_refs   = (match_refs == '1) ? match_refs
                                                       : match_refs + REFS_W'(1);
                     end else if (flags.free_found) begin
                        wr_en    = 1'b1;
                        wr_idx   = free_idx;
                        wr_valid = 1'b1;
                        wr_refs  = REFS_W'(1);
                        live_in  = live_ff + LIVE_W'(1);
                     end else begin
                        status_res = ST_FULL;
                     end
                  end
                  MODE_UNPIN: begin
                     if (flags.found) begin
                        wr_en     = 1'b1;
                        wr_idx    = match_idx;
                        wr_valid  = (refs_dec != '0);
                        wr_reason = match_reason;
                        wr_refs   = refs_dec;
                        if (refs_dec == '0) begin
                           live_in = live_ff - LIVE_W'(1);
                        end
                     end else begin
                        status_res = ST_NOT_FOUND;
                     end
                  end
                  MODE_QUERY: hit_res = flags.found;
                  MODE_RANGE: hit_res = flags.range_hit;
                  MODE_CLEAR: live_in = '0;
                  default: ;
               endcase
            end
         end
         default: state_in = S_INIT;
      endcase
   end

   // result register, parts the table from the response channel
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_status_ff <= status_res;
         rsp_hit_ff    <= hit_res;
         rsp_count_ff  <= live_in[COUNT_W-1:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_entry_count = rsp_count_ff;

endmodule

// ===== rtl/core/rcpt_ram.sv =====
module rcpt_ram #(
   parameter int WIDTH = 84,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/rcpt_scan.sv =====
module rcpt_scan import rcpt_pkg::*; #(
   parameter int CAPACITY  = 32,
   parameter int ADDR_BITS = 48
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic                        ent_vld,
   input  logic [$clog2(CAPACITY)-1:0] ent_idx,
   input  logic                        ent_valid,
   input  logic [ADDR_BITS-1:0]        ent_addr,
   input  logic [REASON_W-1:0]         ent_reason,
   input  logic [REFS_W-1:0]           ent_refs,
   input  logic [ADDR_BITS-1:0]        key_addr,
   input  logic [SIZE_W-1:0]           key_size,
   output scan_flags_type              flags,
   output logic [$clog2(CAPACITY)-1:0] match_idx,
   output logic [REASON_W-1:0]         match_reason,
   output logic [REFS_W-1:0]           match_refs,
   output logic [$clog2(CAPACITY)-1:0] free_idx
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CMP_W = (ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W;

   scan_flags_type      flags_ff, flags_in;
   logic [IDX_W-1:0]    match_idx_ff;
   logic [REASON_W-1:0] match_reason_ff;
   logic [REFS_W-1:0]   match_refs_ff;
   logic [IDX_W-1:0]    free_idx_ff;

   logic                 is_match;
   logic                 is_free;
   logic                 in_range;
   logic [ADDR_BITS-1:0] offset;

   // per-entry compares: exact match, free slot, and base <= a < base + size
   assign offset   = ent_addr - key_addr;
   assign is_match = ent_valid && (ent_addr == key_addr);
   assign is_free  = !ent_valid;
   assign in_range = ent_valid && (ent_addr >= key_addr) &&
                     (CMP_W'(offset) < CMP_W'(key_size));

   // accumulate flags over the scan, first hit wins
   always_comb begin
      flags_in = flags_ff;
      if (start) begin
         flags_in = '0;
      end else if (ent_vld) begin
         if (is_match) begin
            flags_in.found = 1'b1;
         end
         if (is_free) begin
            flags_in.free_found = 1'b1;
         end
         if (in_range) begin
            flags_in.range_hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff <= '0;
      end else begin
         flags_ff <= flags_in;
      end
   end

   // capture the matching entry and the lowest free slot
   always_ff @(posedge clock) begin
      if (ent_vld && !start) begin
         if (is_match && !flags_ff.found) begin
            match_idx_ff    <= ent_idx;
            match_reason_ff <= ent_reason;
            match_refs_ff   <= ent_refs;
         end
         if (is_free && !flags_ff.free_found) begin
            free_idx_ff <= ent_idx;
         end
      end
   end

   assign flags        = flags_ff;
   assign match_idx    = match_idx_ff;
   assign match_reason = match_reason_ff;
   assign match_refs   = match_refs_ff;
   assign free_idx     = free_idx_ff;

endmodule

// ===== rtl/core/rcpt_checker.sv =====
module rcpt_checker import rcpt_pkg::*; #(
   parameter int CAPACITY  = 32,
   parameter int ADDR_BITS = 48
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [MODE_W-1:0]    req_mode,
   input logic [ADDR_BITS-1:0] req_obj_addr,
   input logic [REASON_W-1:0]  req_pin_reason,
   input logic [SIZE_W-1:0]    req_range_size,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [STATUS_W-1:0]  rsp_status,
   input logic                 rsp_hit,
   input logic [COUNT_W-1:0]   rsp_entry_count
);

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_hit) && $stable(rsp_entry_count))
      else $error("response changed while stalled");

   // one transaction at a time: busy right after an accepted request
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while previous one in flight");

   // reset starts the clearing pass with nothing to deliver
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !req_ready && !rsp_valid)
      else $error("block not quiet after reset");

   // a hit only comes with an ok status
   a_hit_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_status == ST_OK)
      else $error("hit reported with error status");

   // table full only when every slot is taken
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_FULL) |-> rsp_entry_count == COUNT_W'(CAPACITY))
      else $error("table full reported with free slots");

endmodule

bind refcounted_pin_table_unit rcpt_checker #(
   .CAPACITY  (CAPACITY),
   .ADDR_BITS (ADDR_BITS)
) u_rcpt_checker (.*);
